FILE: hw/rtl/per_bin_gain_time_smoother_top_macros.svh
// Assertion macros used by the checker file pbgts_chk.sv.
`ifndef PER_BIN_GAIN_TIME_SMOOTHER_TOP_MACROS_SVH
`define PER_BIN_GAIN_TIME_SMOOTHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define PBGTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define PBGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pbgts_pkg.sv
package pbgts_pkg;

    localparam int GAIN_W       = 16;
    localparam int BIN_W        = 11;
    localparam int ALPHA_W      = 16;
    localparam int DEF_MAX_BINS = 1025;

    localparam logic [GAIN_W-1:0] GAIN_ONE      = GAIN_W'(1) << (GAIN_W - 1);
    localparam logic [BIN_W-1:0]  BIN_COUNT_RST = BIN_W'(1025);

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING_ON = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA        = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_COUNT    = CFG_ADDR_W'(2);

    // Stream payload layout
    localparam int S_TDATA_W = ((GAIN_W + 7) / 8) * 8;
    localparam int M_IDX_LSB = GAIN_W;
    localparam int M_USED_W  = GAIN_W + BIN_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic             last;
        logic             smooth;
    } bin_ctl_t;

endpackage

FILE: hw/rtl/pbgts_ctrl.sv
module pbgts_ctrl #(
    parameter int MAX_BINS = pbgts_pkg::DEF_MAX_BINS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pbgts_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pbgts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             advance,
    output pbgts_pkg::bin_ctl_t              ctl,
    output logic [pbgts_pkg::ALPHA_W-1:0]    alpha
);
    import pbgts_pkg::*;

    localparam int LAST_BIN = MAX_BINS - 1;

    logic             smoothing_on_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [BIN_W-1:0] bin_count_reg;
    logic [BIN_W-1:0] bin_cnt_reg;
    logic [BIN_W-1:0] bin_cnt_next;
    logic             primed_reg;
    logic             primed_next;
    logic [BIN_W-1:0] count_m1;
    logic [BIN_W-1:0] idx;
    logic             last;

    // Final bin number of a frame: a count of zero acts as one, clip to memory depth.
    always_comb begin
        if (bin_count_reg == '0) begin
            count_m1 = '0;
        end else if (32'(bin_count_reg) > 32'(MAX_BINS)) begin
            count_m1 = BIN_W'(LAST_BIN);
        end else begin
            count_m1 = bin_count_reg - BIN_W'(1);
        end
    end

    always_comb begin
        if (32'(bin_cnt_reg) > 32'(LAST_BIN)) begin
            idx = BIN_W'(LAST_BIN);
        end else begin
            idx = bin_cnt_reg;
        end
        last = (idx >= count_m1);

        bin_cnt_next = bin_cnt_reg;
        primed_next  = primed_reg;
        if (advance) begin
            if (last) begin
                bin_cnt_next = '0;
                primed_next  = 1'b1;
            end else begin
                bin_cnt_next = idx + BIN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothing_on_reg <= 1'b0;
            alpha_reg        <= '0;
            bin_count_reg    <= BIN_COUNT_RST;
            bin_cnt_reg      <= '0;
            primed_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_SMOOTHING_ON: smoothing_on_reg <= cfg_wdata[0];
                    REG_ALPHA:        alpha_reg        <= cfg_wdata[ALPHA_W-1:0];
                    REG_BIN_COUNT:    bin_count_reg    <= cfg_wdata[BIN_W-1:0];
                    default: ;
                endcase
            end
            bin_cnt_reg <= bin_cnt_next;
            primed_reg  <= primed_next;
        end
    end

    assign ctl.idx    = idx;
    assign ctl.last   = last;
    assign ctl.smooth = smoothing_on_reg && primed_reg;
    assign alpha      = alpha_reg;

endmodule

FILE: hw/rtl/pbgts_mem.sv
module pbgts_mem #(
    parameter int DEPTH  = pbgts_pkg::DEF_MAX_BINS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [pbgts_pkg::GAIN_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [pbgts_pkg::GAIN_W-1:0] wr_data
);
    import pbgts_pkg::*;

    logic [GAIN_W-1:0] mem [DEPTH];
    logic [GAIN_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/pbgts_blend.sv
module pbgts_blend (
    input  logic [pbgts_pkg::GAIN_W-1:0]  gain,
    input  logic [pbgts_pkg::GAIN_W-1:0]  prev,
    input  logic [pbgts_pkg::ALPHA_W-1:0] alpha,
    input  logic                          smooth,
    output logic [pbgts_pkg::GAIN_W-1:0]  result
);
    import pbgts_pkg::*;

    localparam int DIFF_W = GAIN_W + 2;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W - ALPHA_W + 1;

    logic signed [DIFF_W-1:0]        diff;
    logic signed [ALPHA_W:0]         alpha_s;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        rounded;
    logic signed [PROD_W-ALPHA_W-1:0] delta;
    logic signed [SUM_W-1:0]         sum;

    // alpha*prev + (1-alpha)*gain == gain + alpha*(prev - gain)
    always_comb begin
        diff    = $signed({2'b00, prev}) - $signed({2'b00, gain});
        alpha_s = $signed({1'b0, alpha});
        prod    = alpha_s * diff;
        rounded = prod + $signed(PROD_W'(1) << (ALPHA_W - 1));
        delta   = rounded[PROD_W-1:ALPHA_W];
        sum     = $signed(SUM_W'(gain)) + SUM_W'(delta);
        if (!smooth) begin
            result = gain;
        end else if (sum > $signed(SUM_W'(GAIN_ONE))) begin
            result = GAIN_ONE;
        end else begin
            result = sum[GAIN_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/per_bin_gain_time_smoother_top.sv
// Pipeline: an accepted input is held in the stage-1 registers, then its blended result in the output register.
// Throughput: one bin per cycle unless m_tready stalls, set by the gain memory's one read and one write port;
// back-to-back hits on the same bin are forwarded from the blend stage.
// Reset (aresetn low, synchronous): clears handshakes, bin counter, frame flag and
// configuration; the gain memory is not cleared, and smoothing stays off until a first frame has passed.
module per_bin_gain_time_smoother_top #(
    parameter int MAX_BINS = pbgts_pkg::DEF_MAX_BINS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pbgts_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pbgts_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pbgts_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] gain
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pbgts_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] smoothed_gain, [26:16] bin_index
    output logic                             m_tlast
);
    import pbgts_pkg::*;

    localparam int ADDR_W = $clog2(MAX_BINS);

    bin_ctl_t           ctl;
    logic [ALPHA_W-1:0] alpha;
    logic               s_accept;
    logic               s1_adv;
    logic [GAIN_W-1:0]  gain_sat;
    logic [ADDR_W-1:0]  rd_addr;
    logic [GAIN_W-1:0]  rd_data;
    logic [GAIN_W-1:0]  prev;
    logic [GAIN_W-1:0]  result;

    logic               s1_valid_reg;
    logic [GAIN_W-1:0]  s1_gain_reg;
    logic [ALPHA_W-1:0] s1_alpha_reg;
    bin_ctl_t           s1_ctl_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               fwd_sel_reg;
    logic [GAIN_W-1:0]  fwd_data_reg;

    logic               m_valid_reg;
    logic [GAIN_W-1:0]  m_gain_reg;
    logic [BIN_W-1:0]   m_idx_reg;
    logic               m_last_reg;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    assign gain_sat = (s_tdata[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : s_tdata[GAIN_W-1:0];
    assign rd_addr  = ADDR_W'(ctl.idx);

    pbgts_ctrl #(
        .MAX_BINS (MAX_BINS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (s_accept),
        .ctl       (ctl),
        .alpha     (alpha)
    );

    pbgts_mem #(
        .DEPTH  (MAX_BINS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (result)
    );

    // The bin being written this cycle is not yet visible to a read issued at the same edge.
    assign prev = fwd_sel_reg ? fwd_data_reg : rd_data;

    pbgts_blend u_blend (
        .gain   (s1_gain_reg),
        .prev   (prev),
        .alpha  (s1_alpha_reg),
        .smooth (s1_ctl_reg.smooth),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_gain_reg  <= gain_sat;
            s1_alpha_reg <= alpha;
            s1_ctl_reg   <= ctl;
            s1_addr_reg  <= rd_addr;
            fwd_sel_reg  <= s1_adv && (s1_addr_reg == rd_addr);
            fwd_data_reg <= result;
        end
        if (s1_adv) begin
            m_gain_reg <= result;
            m_idx_reg  <= s1_ctl_reg.idx;
            m_last_reg <= s1_ctl_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_idx_reg, m_gain_reg});
    assign m_tlast  = m_last_reg;

endmodule

FILE: hw/rtl/pbgts_chk.sv
`include "per_bin_gain_time_smoother_top_macros.svh"

module pbgts_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pbgts_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import pbgts_pkg::*;

    logic [BIN_W-1:0] exp_idx_reg;
    logic [BIN_W-1:0] out_idx;

    assign out_idx = m_tdata[M_IDX_LSB +: BIN_W];

    // Track the bin number the next result must carry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            exp_idx_reg <= m_tlast ? '0 : out_idx + BIN_W'(1);
        end
    end

    `PBGTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    `PBGTS_ASSERT_NOW(a_ready_when_drained, !m_tvalid, s_tready,
        "input stalled with empty output")

    `PBGTS_ASSERT_NOW(a_bin_sequence, m_tvalid, out_idx == exp_idx_reg,
        "bin number out of sequence")

    `PBGTS_ASSERT_NOW(a_gain_range, m_tvalid, m_tdata[GAIN_W-1:0] <= GAIN_ONE,
        "smoothed gain above one")

endmodule

bind per_bin_gain_time_smoother_top pbgts_chk u_pbgts_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/gain_smoother_checker.sv
`timescale 1ns / 1ps

module gain_smoother_checker
    import pbgts_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BINS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] gain
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [15:0] smoothed_gain, [26:16] bin_index
    input  logic                  m_tlast,
    output int                    mismatch_count,
    output int                    gains_in_flight,
    output int                    gains_checked,
    output int                    frames_closed,
    output int                    bins_stored,
    output int                    bin_cursor
);

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [BIN_W-1:0]  idx;
        logic              last;
    } smoothed_bin_t;

    smoothed_bin_t     expected_bins[$];
    logic [GAIN_W-1:0] prior_gain [DEPTH];
    logic              primed;
    logic              smooth_en;
    logic [ALPHA_W-1:0] weight;
    logic [BIN_W-1:0]  count_reg;
    logic [BIN_W-1:0]  cursor;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%t: %s wrong on result %0d: got %0d, want %0d",
                 $time, what, gains_checked, got, want);
        mismatch_count++;
    endtask

    // Blend one gain into its bin's memory and step the bin counter.
    function automatic smoothed_bin_t advance_bin(input logic [GAIN_W-1:0] raw);
        int                frame_len;
        int                idx;
        logic [GAIN_W-1:0] g;
        logic [GAIN_W-1:0] res;
        logic [33:0]       acc;
        smoothed_bin_t     r;
        if (count_reg == 0) begin
            frame_len = 1;
        end else if (int'(count_reg) > DEPTH) begin
            frame_len = DEPTH;
        end else begin
            frame_len = int'(count_reg);
        end
        g = (raw > GAIN_ONE) ? GAIN_ONE : raw;
        idx = int'(cursor);
        if (idx >= DEPTH) begin
            idx = DEPTH - 1;
        end
        if (smooth_en && primed) begin
            acc = 34'(weight) * 34'(prior_gain[idx])
                + (34'd65536 - 34'(weight)) * 34'(g) + 34'd32768;
            if (acc[33:16] > 18'(GAIN_ONE)) begin
                res = GAIN_ONE;
            end else begin
                res = acc[GAIN_W+15:16];
            end
        end else begin
            res = g;
        end
        prior_gain[idx] = res;
        if (idx >= bins_stored) begin
            bins_stored = idx + 1;
        end
        r.gain = res;
        r.idx  = BIN_W'(idx);
        r.last = (idx + 1 >= frame_len);
        if (r.last) begin
            cursor = '0;
            primed = 1'b1;
        end else begin
            cursor = BIN_W'(idx + 1);
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        smoothed_bin_t want;
        if (!aresetn) begin
            primed          = 1'b0;
            smooth_en       = 1'b0;
            weight          = '0;
            count_reg       = BIN_COUNT_RST;
            cursor          = '0;
            expected_bins.delete();
            mismatch_count  = 0;
            gains_in_flight = 0;
            gains_checked   = 0;
            frames_closed   = 0;
            bins_stored     = 0;
            bin_cursor      = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = expected_bins.pop_front();
                    if (m_tdata[GAIN_W-1:0] !== want.gain) begin
                        report_mismatch("smoothed_gain", m_tdata[GAIN_W-1:0], want.gain);
                    end
                    if (m_tdata[M_IDX_LSB +: BIN_W] !== want.idx) begin
                        report_mismatch("bin_index", m_tdata[M_IDX_LSB +: BIN_W], want.idx);
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("last_in_frame", m_tlast, want.last);
                    end
                    if (want.last) begin
                        frames_closed++;
                    end
                    gains_checked++;
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_SMOOTHING_ON: smooth_en = cfg_wdata[0];
                    REG_ALPHA:        weight    = cfg_wdata[ALPHA_W-1:0];
                    REG_BIN_COUNT:    count_reg = cfg_wdata[BIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_bins.push_back(advance_bin(s_tdata[GAIN_W-1:0]));
            end
            gains_in_flight = expected_bins.size();
            bin_cursor      = int'(cursor);
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pbgts_pkg::*;

    localparam int ITEMS_TARGET = 1850;
    localparam int CALM_TAIL    = 250;
    localparam int HOLD_CYCLES  = 150;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [15:0] gain
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [15:0] smoothed_gain, [26:16] bin_index
    logic                  m_tlast;

    int mismatch_count;
    int gains_in_flight;
    int gains_checked;
    int frames_closed;
    int bins_stored;
    int bin_cursor;

    int gains_sent      = 0;
    int settings_loaded = 0;
    int tx_gap_pct      = 0;
    int rx_stall_pct    = 0;
    bit calm            = 1'b0;
    bit hold_req        = 1'b0;
    bit hold_served     = 1'b0;
    bit big_frame_done  = 1'b0;

    per_bin_gain_time_smoother_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gain_smoother_checker smoother_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .gains_in_flight (gains_in_flight),
        .gains_checked   (gains_checked),
        .frames_closed   (frames_closed),
        .bins_stored     (bins_stored),
        .bin_cursor      (bin_cursor)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_ONE;
            2:       return GAIN_W'($urandom_range(32769, 65535));
            default: return GAIN_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return ALPHA_W'(32768);
            default: return ALPHA_W'($urandom);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    function automatic int effective_bins(input logic [BIN_W-1:0] c);
        if (c == 0) return 1;
        if (int'(c) > DEF_MAX_BINS) return DEF_MAX_BINS;
        return int'(c);
    endfunction

    task automatic load_settings(input logic [CFG_DATA_W-1:0] on_word,
                                 input logic [CFG_DATA_W-1:0] alpha_word,
                                 input logic [CFG_DATA_W-1:0] count_word);
        logic [CFG_DATA_W-1:0] on_safe;
        on_safe = on_word;
        // hold smoothing off until every bin it could read has been written once
        if (effective_bins(count_word[BIN_W-1:0]) > bins_stored || bin_cursor >= bins_stored) begin
            on_safe[0] = 1'b0;
        end
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SMOOTHING_ON;
        cfg_wdata <= on_safe;
        @(negedge aclk);
        cfg_addr  <= REG_ALPHA;
        cfg_wdata <= alpha_word;
        @(negedge aclk);
        cfg_addr  <= REG_BIN_COUNT;
        cfg_wdata <= count_word;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        settings_loaded++;
    endtask

    task automatic feed_gain(input logic [GAIN_W-1:0] g);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(g);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        gains_sent++;
    endtask

    task automatic pause_sender();
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (gains_in_flight != 0) @(negedge aclk);
    endtask

    task automatic feed_run(input int n);
        repeat (n) begin
            feed_gain(pick_gain());
            pause_sender();
        end
        drain();
    endtask

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_served = 1'b1;
            end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int                    frame_len;
        int                    n;
        logic [CFG_DATA_W-1:0] on_word;
        logic [CFG_DATA_W-1:0] alpha_word;
        logic [CFG_DATA_W-1:0] count_word;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_SMOOTHING_ON;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first frame passes and stores; saturation of gains above one
        load_settings(16'd1, 16'd0, 16'd4);
        feed_gain(16'h0000);
        feed_gain(16'h8000);
        feed_gain(16'hFFFF);
        feed_gain(16'h0001);
        drain();
        // heaviest weight on the stored value
        load_settings(16'd1, 16'hFFFF, 16'd4);
        feed_gain(16'h8000);
        feed_gain(16'h0000);
        feed_gain(16'hFFFF);
        feed_gain(16'h7FFF);
        drain();
        // no weight on the stored value; stop three bins into the frame
        load_settings(16'd1, 16'd0, 16'd4);
        feed_gain(16'h1234);
        feed_gain(16'h8001);
        feed_gain(16'h4000);
        drain();
        // lower the frame length below the counter mid-frame
        load_settings(16'd1, 16'h8000, 16'd2);
        feed_gain(16'h2000);
        feed_gain(16'hFFFF);
        feed_gain(16'h0000);
        drain();
        // zero length acts as one bin per frame
        load_settings(16'd1, 16'h8000, 16'd0);
        feed_gain(16'h8000);
        feed_gain(16'h0001);
        drain();
        // toggle smoothing in the middle of a frame
        load_settings(16'd1, 16'd40000, 16'd4);
        feed_gain(16'h6000);
        feed_gain(16'h0100);
        drain();
        load_settings(16'd0, 16'd40000, 16'd4);
        feed_gain(16'h7000);
        feed_gain(16'h0200);
        drain();

        while (gains_sent < ITEMS_TARGET) begin
            calm         = (gains_sent >= ITEMS_TARGET - CALM_TAIL);
            tx_gap_pct   = pick_pct();
            rx_stall_pct = pick_pct();
            alpha_word   = pick_alpha();
            on_word      = ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0;
            if (!big_frame_done && gains_sent > 400) begin
                // one full frame at the largest size, starting from wherever the counter is
                count_word = ($urandom_range(0, 1) != 0) ? 16'd2047 : 16'(DEF_MAX_BINS);
                big_frame_done = 1'b1;
                frame_len = DEF_MAX_BINS;
                load_settings(on_word, alpha_word, count_word);
                n = (bin_cursor >= frame_len) ? 1 : frame_len - bin_cursor;
            end else begin
                case ($urandom_range(0, 9))
                    0:          count_word = 16'd0;
                    1:          count_word = 16'd1;
                    2:          count_word = 16'd2;
                    3, 4, 5, 6: count_word = 16'($urandom_range(3, 16));
                    7, 8:       count_word = 16'($urandom_range(17, 64));
                    default: begin
                        count_word = big_frame_done ? 16'($urandom_range(1025, 2047))
                                                    : 16'($urandom_range(3, 16));
                    end
                endcase
                // unused register bits must be ignored
                if ($urandom_range(0, 3) == 0) begin
                    on_word[CFG_DATA_W-1:1]        = (CFG_DATA_W-1)'($urandom);
                    count_word[CFG_DATA_W-1:BIN_W] = (CFG_DATA_W-BIN_W)'($urandom);
                end
                frame_len = effective_bins(count_word[BIN_W-1:0]);
                load_settings(on_word, alpha_word, count_word);
                if (frame_len > 64) begin
                    n = $urandom_range(1, 40);
                end else if ($urandom_range(0, 3) != 0) begin
                    n = ((bin_cursor >= frame_len) ? 1 : frame_len - bin_cursor)
                      + frame_len * $urandom_range(0, 3);
                end else begin
                    n = $urandom_range(1, 2 * frame_len + 3);
                end
            end
            if (!hold_served && gains_sent > 900) begin
                // sender keeps offering while the result side holds off
                tx_gap_pct = 0;
                hold_req   = 1'b1;
                n += 48;
            end
            feed_run(n);
        end

        drain();
        repeat (8) @(negedge aclk);

        $display("covered %0d gain transactions under %0d register settings, %0d frames closed",
                 gains_sent, settings_loaded, frames_closed);
        $display("%0d results compared, %0d mismatches", gains_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
